/* hw/rtl/sre_pkg.sv */
// Shared types and constants for the sprite run-length RGB555 expander.
`timescale 1ns / 1ps

package sre_pkg;

  localparam int unsigned RegW  = 24;
  localparam int unsigned ModeW = 2;
  localparam int unsigned IdxW  = 2;
  localparam int unsigned WordW = 32;

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegImageMode       = 2'd0;
  localparam logic [IdxW-1:0] RegImageLength     = 2'd1;
  localparam logic [IdxW-1:0] RegPlainPartLength = 2'd2;

  // Image modes
  localparam logic [ModeW-1:0] ModePlain = 2'd0;
  localparam logic [ModeW-1:0] ModeRun   = 2'd1;
  localparam logic [ModeW-1:0] ModeMixed = 2'd2;

  typedef enum logic [1:0] {
    PhStart = 2'd0,
    PhLow   = 2'd1,
    PhHigh  = 2'd2,
    PhSkip  = 2'd3
  } sre_phase_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [RegW-1:0]  length;
    logic [RegW-1:0]  plain_len;
  } sre_cfg_t;

  typedef struct packed {
    logic             have;
    logic             last;
    logic [WordW-1:0] word;
  } sre_res_t;

endpackage

/* hw/rtl/sprite_rle_rgb555_expander.sv */
// Top level of the sprite expander: config registers, decoder and output skid stage.
//
//  channel   dir  request when                 payload
//  s_axis    in   s_axis_tvalid & tready       tdata[7:0] source_byte
//  m_axis    out  m_axis_tvalid & tready       tdata[31:0] pixel_word, tlast end_of_image
//  cfg       in   cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// One source byte per cycle while s_axis_tready is high; each byte is decoded in the cycle it
// is taken, and any word it yields lands in the output stage (main or skid register) on that edge.
// A two-entry output stage (main + skid) keeps s_axis_tready high while one word waits.
// Reset clears the decode phase, counters and both output entries; config resets to 0.
`timescale 1ns / 1ps

module sprite_rle_rgb555_expander #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] source_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] pixel_word
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);

  sre_pkg::sre_cfg_t cfg_q;
  sre_pkg::sre_res_t res;

  logic        in_req;
  logic        push;
  logic        pop;
  logic        main_valid_q, skid_valid_q;
  logic [31:0] main_word_q, skid_word_q;
  logic        main_last_q, skid_last_q;

  assign s_axis_tready = !skid_valid_q;
  assign in_req        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sre_pkg::RegImageMode:       cfg_q.mode      <= cfg_wdata_i[1:0];
        sre_pkg::RegImageLength:     cfg_q.length    <= cfg_wdata_i;
        sre_pkg::RegPlainPartLength: cfg_q.plain_len <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sre_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req),
    .byte_i (s_axis_tdata),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign push = in_req && res.have;
  assign pop  = main_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push;
      end
    end else if (push) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      main_word_q <= skid_word_q;
      main_last_q <= skid_last_q;
    end else if (push && (pop || !main_valid_q)) begin
      main_word_q <= res.word;
      main_last_q <= res.last;
    end
    if (push && main_valid_q && !pop) begin
      skid_word_q <= res.word;
      skid_last_q <= res.last;
    end
  end

  assign m_axis_tvalid = main_valid_q;
  assign m_axis_tdata  = main_word_q;
  assign m_axis_tlast  = main_last_q;

endmodule

/* hw/rtl/sre_core.sv */
// Decode state and per-byte result logic of the sprite expander.
`timescale 1ns / 1ps

module sre_core #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_i,
  input  logic [7:0]       byte_i,
  input  sre_pkg::sre_cfg_t cfg_i,
  output sre_pkg::sre_res_t res_o
);

  localparam logic [7:0] CtrlSkip = 8'hFF;

  function automatic logic [31:0] widen(input logic [15:0] c);
    widen = {8'h00, c[14:10], c[14:12], c[9:5], c[9:7], c[4:0], c[4:2]};
  endfunction

  sre_pkg::sre_phase_e    phase_q, phase_d;
  logic [7:0]             run_q, run_d;
  logic [7:0]             held_q, held_d;
  logic [LENGTH_BITS-1:0] seen_q, seen_d;

  logic [LENGTH_BITS-1:0] seen_inc;
  logic [LENGTH_BITS-1:0] len_cmp;
  logic [31:0]            len_ext;
  logic                   last;
  logic                   plain;
  logic                   below_plain;

  assign seen_inc    = seen_q + LENGTH_BITS'(1);
  assign len_ext     = {8'h00, cfg_i.length};
  assign len_cmp     = len_ext[LENGTH_BITS-1:0];
  assign last        = (seen_inc == len_cmp);
  assign below_plain = (32'(seen_q) < {8'h00, cfg_i.plain_len});
  assign plain       = (cfg_i.mode == sre_pkg::ModeRun)   ? 1'b0 :
                       (cfg_i.mode == sre_pkg::ModeMixed) ? below_plain : 1'b1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      sre_pkg::PhStart: begin
        if (plain) begin
          phase_d = sre_pkg::PhHigh;
        end else if (byte_i == CtrlSkip) begin
          phase_d = sre_pkg::PhSkip;
        end else if (byte_i != 8'h00) begin
          phase_d = sre_pkg::PhLow;
        end else begin
          phase_d = sre_pkg::PhStart;
        end
      end
      sre_pkg::PhLow:  phase_d = sre_pkg::PhHigh;
      sre_pkg::PhHigh: phase_d = (run_q != 8'h00) ? sre_pkg::PhLow : sre_pkg::PhStart;
      sre_pkg::PhSkip: phase_d = sre_pkg::PhStart;
      default:         phase_d = sre_pkg::PhStart;
    endcase
    if (last) begin
      phase_d = sre_pkg::PhStart;
    end
  end

  // result and data state
  always_comb begin
    res_o  = '0;
    held_d = held_q;
    run_d  = run_q;
    case (phase_q)
      sre_pkg::PhStart: begin
        if (plain) begin
          held_d = byte_i;
          run_d  = 8'h00;
        end else begin
          res_o.word = {24'h000000, byte_i};
          res_o.have = 1'b1;
          if (byte_i != CtrlSkip) begin
            run_d = byte_i;
          end
        end
      end
      sre_pkg::PhLow: begin
        held_d = byte_i;
        run_d  = run_q - 8'h01;
      end
      sre_pkg::PhHigh: begin
        res_o.word = widen({byte_i, held_q});
        res_o.have = 1'b1;
      end
      sre_pkg::PhSkip: begin
        res_o.word = {24'h000000, byte_i};
        res_o.have = 1'b1;
      end
      default: ;
    endcase
    seen_d = seen_inc;
    if (last) begin
      if (!res_o.have) begin
        res_o.word = widen({8'h00, held_d});
        res_o.have = 1'b1;
      end
      res_o.last = 1'b1;
      held_d     = 8'h00;
      run_d      = 8'h00;
      seen_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sre_pkg::PhStart;
      run_q   <= 8'h00;
      held_q  <= 8'h00;
      seen_q  <= '0;
    end else if (req_i) begin
      phase_q <= phase_d;
      run_q   <= run_d;
      held_q  <= held_d;
      seen_q  <= seen_d;
    end
  end

endmodule
